@@ rtl/ppru_pkg.sv @@
// Package for the page pixel recolor / unmatte block.
// Shared types, register indexes, mode codes and the divide-by-255 helper.
// No dependencies.
package ppru_pkg;

   localparam int COORD_FIELD_W = 15;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 61;
   localparam int RGN_W         = 61;

   // region packing
   localparam int RGN_LEFT_LSB = 0;
   localparam int RGN_TOP_LSB  = 15;
   localparam int RGN_WID_LSB  = 30;
   localparam int RGN_HGT_LSB  = 45;
   localparam int RGN_ELL_BIT  = 60;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FG_COLOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BG_COLOR = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESERVE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCE    = 3'd4;

   // mode codes
   localparam logic [2:0] MODE_PASS          = 3'd0;
   localparam logic [2:0] MODE_RECOLOR       = 3'd1;
   localparam logic [2:0] MODE_INVERT        = 3'd2;
   localparam logic [2:0] MODE_INVERT_UNMATTE = 3'd3;
   localparam logic [2:0] MODE_UNMATTE_WHITE = 3'd4;

   // c[2] red, c[1] green, c[0] blue (same order as the color registers)
   typedef struct packed {
      logic [7:0]      a;
      logic [2:0][7:0] c;
   } pixel_type;

   // exact floor(x/255) for x below 65280
   function automatic logic [7:0] div255(input logic [16:0] x);
      logic [16:0] t;
      t = x + 17'd1 + {8'd0, x[16:8]};
      return t[15:8];
   endfunction

endpackage

@@ rtl/ppru_if.sv @@
// Channel interfaces for the page pixel recolor / unmatte block.
// Depends on ppru_pkg.
interface ppru_req_if;
   import ppru_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [COORD_FIELD_W-1:0] pixel_x;
   logic [COORD_FIELD_W-1:0] pixel_y;
   logic [7:0]               in_alpha;
   logic [7:0]               in_red;
   logic [7:0]               in_green;
   logic [7:0]               in_blue;
   modport source (output valid, pixel_x, pixel_y, in_alpha, in_red, in_green, in_blue,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, in_alpha, in_red, in_green, in_blue,
                   output ready);
endinterface

interface ppru_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_alpha;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   modport source (output valid, out_alpha, out_red, out_green, out_blue, input ready);
   modport sink   (input valid, out_alpha, out_red, out_green, out_blue, output ready);
endinterface

interface ppru_csr_if;
   import ppru_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/page_pixel_recolor_unmatte.sv @@
// Top level of the page pixel recolor / unmatte block.
// Depends on ppru_pkg, ppru_if (channel interfaces) and ppru_region.
//
//   channel   dir  beat contents
//   req_chan  in   pixel_x, pixel_y, in_alpha, in_red, in_green, in_blue
//   rsp_chan  out  out_alpha, out_red, out_green, out_blue
//   csr_chan  in   index (0 mode .. 4 force region), data
//
// One beat per cycle sustained while rsp_chan is ready.
// The pipe depth is set by the ellipse test (squares, then 30x30 products) and the
// 2-bit-per-stage restoring divider that unmixes the channels.
// Reset (synchronous, active high) clears the valid bits and the config
// registers; datapath registers are not reset.
// A stalled rsp beat freezes the whole pipe; req_chan.ready drops with it.
module page_pixel_recolor_unmatte
   import ppru_pkg::*;
#(
   parameter int COORD_BITS = 15
) (
   input  logic     clock,
   input  logic     reset,
   ppru_req_if.sink   req_chan,
   ppru_rsp_if.source rsp_chan,
   ppru_csr_if.sink   csr_chan
);
   localparam int NSTAGE = 12;
   localparam int NDIV   = 4;  // divider stages, 2 quotient bits each

   typedef struct packed {
      pixel_type       pix;      // pixel before unmatting
      logic [7:0]      cov;
      logic [7:0]      alpha_n;
      logic [2:0][16:0] rem;
      logic [2:0][7:0] q;
      logic [2:0]      over;     // quotient past 255, clamps
      logic            um;
      logic            zr;
      logic            full;
   } div_type;

   // ---------------- configuration registers
   logic [2:0]       mode_ff;
   logic [23:0]      fg_ff, bg_ff;
   logic [RGN_W-1:0] pres_ff, forc_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
         fg_ff   <= 24'h000000;
         bg_ff   <= 24'hFFFFFF;
         pres_ff <= '0;
         forc_ff <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            REG_MODE:     mode_ff <= csr_chan.data[2:0];
            REG_FG_COLOR: fg_ff   <= csr_chan.data[23:0];
            REG_BG_COLOR: bg_ff   <= csr_chan.data[23:0];
            REG_PRESERVE: pres_ff <= csr_chan.data;
            REG_FORCE:    forc_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // ---------------- flow control: whole pipe moves together
   logic                advance;
   logic [NSTAGE-1:0]   vld_ff, vld_in;

   assign advance        = !vld_ff[NSTAGE-1] || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign vld_in         = {vld_ff[NSTAGE-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- region tests (4 stages)
   logic pres_cov, forc_cov;

   ppru_region #(.COORD_BITS(COORD_BITS)) u_pres (
      .clock  (clock),
      .enable (advance),
      .region (pres_ff),
      .x      (req_chan.pixel_x[COORD_BITS-1:0]),
      .y      (req_chan.pixel_y[COORD_BITS-1:0]),
      .covers (pres_cov)
   );

   ppru_region #(.COORD_BITS(COORD_BITS)) u_forc (
      .clock  (clock),
      .enable (advance),
      .region (forc_ff),
      .x      (req_chan.pixel_x[COORD_BITS-1:0]),
      .y      (req_chan.pixel_y[COORD_BITS-1:0]),
      .covers (forc_cov)
   );

   // ---------------- pixel delay, stages 1..4
   pixel_type dly_ff [4];
   pixel_type req_pix_in;

   assign req_pix_in = '{a: req_chan.in_alpha,
                         c: {req_chan.in_red, req_chan.in_green, req_chan.in_blue}};

   always_ff @(posedge clock) begin
      if (advance) begin
         dly_ff[0] <= req_pix_in;
         dly_ff[1] <= dly_ff[0];
         dly_ff[2] <= dly_ff[1];
         dly_ff[3] <= dly_ff[2];
      end
   end

   // ---------------- stage 5: invert, recolor blend products
   logic            xform;
   logic [12:0]     gray_sum;
   logic [7:0]      bw, fw;
   pixel_type       st5_pix_in;
   logic [2:0][15:0] st5_sum_in;
   logic            st5_rc_in;

   pixel_type       st5_pix_ff;
   logic [2:0][15:0] st5_sum_ff;
   logic            st5_rc_ff;

   always_comb begin
      xform    = forc_cov || !pres_cov;
      gray_sum = 13'(dly_ff[3].c[2]) * 13'd11 + 13'(dly_ff[3].c[1]) * 13'd16
               + 13'(dly_ff[3].c[0]) * 13'd5;
      bw       = gray_sum[12:5];
      fw       = 8'd255 - bw;
      st5_pix_in = dly_ff[3];
      if (xform && (mode_ff == MODE_INVERT || mode_ff == MODE_INVERT_UNMATTE)) begin
         st5_pix_in.c = ~dly_ff[3].c;
      end
      for (int i = 0; i < 3; i++) begin
         st5_sum_in[i] = fg_ff[8*i +: 8] * fw + bg_ff[8*i +: 8] * bw;
      end
      st5_rc_in = xform && (mode_ff == MODE_RECOLOR);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st5_pix_ff <= st5_pix_in;
         st5_sum_ff <= st5_sum_in;
         st5_rc_ff  <= st5_rc_in;
      end
   end

   // ---------------- stage 6: finish the blend (/255)
   pixel_type st6_pix_in, st6_pix_ff;

   always_comb begin
      st6_pix_in = st5_pix_ff;
      if (st5_rc_ff) begin
         for (int i = 0; i < 3; i++) begin
            st6_pix_in.c[i] = div255({1'b0, st5_sum_ff[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st6_pix_ff <= st6_pix_in;
      end
   end

   // ---------------- stage 7: coverage against paper
   logic [7:0]  paper;
   logic [7:0]  cov_in;
   logic [2:0][7:0] chan_diff;
   pixel_type   st7_pix_ff;
   logic [7:0]  st7_cov_ff;
   logic        st7_um_ff, st7_zr_ff, st7_full_ff;

   assign paper = (mode_ff == MODE_INVERT_UNMATTE) ? 8'd0 : 8'd255;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan_diff[i] = (st6_pix_ff.c[i] >= paper) ? st6_pix_ff.c[i] - paper
                                                   : paper - st6_pix_ff.c[i];
      end
      cov_in = chan_diff[2];
      if (chan_diff[1] > cov_in) cov_in = chan_diff[1];
      if (chan_diff[0] > cov_in) cov_in = chan_diff[0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st7_pix_ff  <= st6_pix_ff;
         st7_cov_ff  <= cov_in;
         st7_um_ff   <= (mode_ff == MODE_INVERT_UNMATTE) || (mode_ff == MODE_UNMATTE_WHITE);
         st7_zr_ff   <= (cov_in == 8'd0) || (st6_pix_ff.a == 8'd0);
         st7_full_ff <= (cov_in == 8'd255);
      end
   end

   // ---------------- stage 8: numerators, alpha, overflow check
   div_type       dv_ff [NDIV];
   div_type       dv0_in;
   logic [17:0]   num;
   logic [16:0]   cov_hi;

   always_comb begin
      dv0_in.pix     = st7_pix_ff;
      dv0_in.cov     = st7_cov_ff;
      dv0_in.alpha_n = div255(17'(st7_pix_ff.a) * 17'(st7_cov_ff) + 17'd127);
      dv0_in.q       = '0;
      dv0_in.um      = st7_um_ff;
      dv0_in.zr      = st7_zr_ff;
      dv0_in.full    = st7_full_ff;
      cov_hi         = {1'b0, st7_cov_ff, 8'd0};
      num            = '0;
      for (int i = 0; i < 3; i++) begin
         num = 18'(st7_pix_ff.c[i]) * 18'd255
             - 18'(paper) * 18'(8'd255 - st7_cov_ff)
             + 18'(st7_cov_ff[7:1]);
         dv0_in.rem[i]  = (num[17] || num == '0) ? 17'd0 : num[16:0];
         dv0_in.over[i] = (dv0_in.rem[i] >= cov_hi);
      end
   end

   // ---------------- stages 9..11 and output: restoring divide, 2 bits a stage
   div_type   dv_in [NDIV];
   pixel_type out_in, out_ff;

   always_comb begin
      for (int s = 0; s < NDIV; s++) begin
         dv_in[s] = dv_ff[s];
         for (int i = 0; i < 3; i++) begin
            for (int b = 1; b >= 0; b--) begin
               if (dv_in[s].rem[i] >= (17'(dv_ff[s].cov) << (2*(NDIV-1-s) + b))) begin
                  dv_in[s].rem[i] = dv_in[s].rem[i]
                                  - (17'(dv_ff[s].cov) << (2*(NDIV-1-s) + b));
                  dv_in[s].q[i][2*(NDIV-1-s) + b] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dv_ff[0] <= dv0_in;
         for (int s = 1; s < NDIV; s++) begin
            dv_ff[s] <= dv_in[s-1];
         end
      end
   end

   // zero coverage or zero alpha wins over full coverage
   always_comb begin
      out_in = dv_in[NDIV-1].pix;
      if (dv_in[NDIV-1].um) begin
         if (dv_in[NDIV-1].zr) begin
            out_in = '0;
         end else if (!dv_in[NDIV-1].full) begin
            out_in.a = dv_in[NDIV-1].alpha_n;
            for (int i = 0; i < 3; i++) begin
               out_in.c[i] = dv_in[NDIV-1].over[i] ? 8'd255 : dv_in[NDIV-1].q[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid     = vld_ff[NSTAGE-1];
   assign rsp_chan.out_alpha = out_ff.a;
   assign rsp_chan.out_red   = out_ff.c[2];
   assign rsp_chan.out_green = out_ff.c[1];
   assign rsp_chan.out_blue  = out_ff.c[0];

endmodule

@@ rtl/ppru_region.sv @@
// Pipelined rectangle / inscribed-ellipse hit test, four register stages.
// Depends on ppru_pkg.
module ppru_region
   import ppru_pkg::*;
#(
   parameter int COORD_BITS = 15
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [RGN_W-1:0]      region,
   input  logic [COORD_BITS-1:0] x,
   input  logic [COORD_BITS-1:0] y,
   output logic                  covers
);
   localparam int CB = COORD_BITS;

   logic [CB-1:0] left, top, wid, hgt;
   logic [CB:0]   x_end, y_end, px, py;
   logic          inside_in;
   logic [CB-1:0] ax_in, ay_in;

   // stage 1
   logic          s1_inside_ff, s1_ell_ff;
   logic [CB-1:0] s1_ax_ff, s1_ay_ff, s1_w_ff, s1_h_ff;
   // stage 2
   logic          s2_inside_ff, s2_ell_ff;
   logic [2*CB-1:0] s2_ax2_ff, s2_ay2_ff, s2_w2_ff, s2_h2_ff;
   // stage 3
   logic          s3_inside_ff, s3_ell_ff;
   logic [4*CB-1:0] s3_t1_ff, s3_t2_ff, s3_t3_ff;
   // stage 4
   logic          s4_cover_ff;
   logic [4*CB:0] lhs;
   logic          cover_in;

   always_comb begin
      left  = region[RGN_LEFT_LSB +: CB];
      top   = region[RGN_TOP_LSB  +: CB];
      wid   = region[RGN_WID_LSB  +: CB];
      hgt   = region[RGN_HGT_LSB  +: CB];
      x_end = {1'b0, left} + {1'b0, wid};
      y_end = {1'b0, top} + {1'b0, hgt};
      inside_in = (wid != '0) && (hgt != '0) && (x >= left) && ({1'b0, x} < x_end)
                  && (y >= top) && ({1'b0, y} < y_end);
      // pixel-center offset, doubled: 2(x-left)+1 against width
      px = {(x - left), 1'b1};
      py = {(y - top), 1'b1};
      ax_in = (px >= {1'b0, wid}) ? CB'(px - {1'b0, wid}) : CB'({1'b0, wid} - px);
      ay_in = (py >= {1'b0, hgt}) ? CB'(py - {1'b0, hgt}) : CB'({1'b0, hgt} - py);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s1_inside_ff <= inside_in;
         s1_ell_ff    <= region[RGN_ELL_BIT];
         s1_ax_ff     <= ax_in;
         s1_ay_ff     <= ay_in;
         s1_w_ff      <= wid;
         s1_h_ff      <= hgt;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s2_inside_ff <= s1_inside_ff;
         s2_ell_ff    <= s1_ell_ff;
         s2_ax2_ff    <= s1_ax_ff * s1_ax_ff;
         s2_ay2_ff    <= s1_ay_ff * s1_ay_ff;
         s2_w2_ff     <= s1_w_ff * s1_w_ff;
         s2_h2_ff     <= s1_h_ff * s1_h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s3_inside_ff <= s2_inside_ff;
         s3_ell_ff    <= s2_ell_ff;
         s3_t1_ff     <= s2_ax2_ff * s2_h2_ff;
         s3_t2_ff     <= s2_ay2_ff * s2_w2_ff;
         s3_t3_ff     <= s2_w2_ff * s2_h2_ff;
      end
   end

   always_comb begin
      lhs      = {1'b0, s3_t1_ff} + {1'b0, s3_t2_ff};
      cover_in = s3_inside_ff && (!s3_ell_ff || (lhs <= {1'b0, s3_t3_ff}));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s4_cover_ff <= cover_in;
      end
   end

   assign covers = s4_cover_ff;

endmodule
